/* src/cnv3_pkg.sv */
// ----------------------------------------------------------------------------
// cnv3_pkg
// Types and constants shared by the 3x3 same-padded convolution plane unit.
// ----------------------------------------------------------------------------
package cnv3_pkg;

	localparam int DATA_BITS = 16;
	localparam int KSIZE     = 3;
	localparam int NTAPS     = KSIZE * KSIZE;

	// Input actions
	localparam logic [1:0] ACT_WEIGHT = 2'd0;
	localparam logic [1:0] ACT_BIAS   = 2'd1;
	localparam logic [1:0] ACT_PIXEL  = 2'd2;
	localparam logic [1:0] ACT_SPARE  = 2'd3;

	// Configuration register map
	localparam int         CFG_IDX_BITS     = 4;
	localparam int         CFG_BITS         = 9;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 4'd1;

	typedef struct packed {
		logic [1:0]                  action;
		logic [3:0]                  tap_index;
		logic signed [DATA_BITS-1:0] sample;
		logic                        first_plane;
		logic                        last_plane;
	} in_item_t;

	typedef struct packed {
		logic [7:0]         out_col;
		logic [7:0]         out_row;
		logic signed [31:0] out_value;
		logic               frame_done;
	} out_item_t;

endpackage

/* src/conv3x3_same_relu_plane_unit.sv */
// ----------------------------------------------------------------------------
// conv3x3_same_relu_plane_unit
// Stride-1 3x3 zero-padded convolution over one plane, accumulated across
// planes in an accumulator memory, with bias, ReLU and 32-bit saturation.
//
//   channel   direction  handshake          payload
//   in        input      in_valid/in_stall   in_item_t
//   out       output     out_valid/out_stall out_item_t
//   cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One request is taken per cycle while in_stall is low. A pixel that
// finishes k output pixels (k is 2 at a row end and 2 to 4 on the last row)
// holds the input while its jobs issue one by one, since the job issue
// stage and the accumulator port serve one output pixel a cycle.
// A job whose accumulator entry is still in the MAC pipe waits; this only
// happens on planes of no more pixels than the pipe has stages.
// Reset clears control state, weights and bias; no clearing pass is run.
// ----------------------------------------------------------------------------
module conv3x3_same_relu_plane_unit
	import cnv3_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int ACC_BITS   = 40
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  in_item_t                in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output out_item_t               out_data,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	localparam int D    = DATA_BITS;
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int WVB  = $clog2(MAX_WIDTH + 1);
	localparam int HVB  = $clog2(MAX_HEIGHT + 1);
	localparam int XWW  = (CFG_BITS > WVB) ? CFG_BITS : WVB;
	localparam int XWH  = (CFG_BITS > HVB) ? CFG_BITS : HVB;
	localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int PW   = (ACC_BITS > 2 * D) ? ACC_BITS : 2 * D;
	localparam int OW   = (ACC_BITS > 33) ? ACC_BITS : 33;
	localparam int NSTG = NTAPS + 1;

	localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
	localparam logic signed [OW-1:0]       OUT_MAX = OW'(2147483647);

	typedef struct packed {
		logic [AW-1:0]       idx;
		logic [7:0]          col;
		logic [7:0]          row;
		logic                done;
		logic                first;
		logic                last;
		logic signed [D-1:0] bias;
	} job_t;

	function automatic logic signed [ACC_BITS-1:0] sat_add(
		input logic signed [ACC_BITS-1:0] a,
		input logic signed [ACC_BITS-1:0] b
	);
		logic signed [ACC_BITS:0] s;
		s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
		if (s[ACC_BITS] != s[ACC_BITS-1]) begin
			return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_BITS-1:0];
	endfunction

	function automatic logic signed [ACC_BITS-1:0] prod_clamp(
		input logic signed [2*D-1:0] p
	);
		logic signed [PW-1:0] pe;
		pe = PW'(p);
		if (pe > PW'(ACC_MAX)) begin
			return ACC_MAX;
		end
		if (pe < PW'(ACC_MIN)) begin
			return ACC_MIN;
		end
		return ACC_BITS'(pe);
	endfunction

	// Configuration and effective sizes
	logic [CFG_BITS-1:0] width_q, height_q;
	logic [WVB-1:0]      w_eff;
	logic [HVB-1:0]      h_eff;
	logic [CW-1:0]       w_last;
	logic [RW-1:0]       h_last;
	logic                cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready &&
		(cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

	always_comb begin
		logic [XWW-1:0] wx;
		logic [XWH-1:0] hx;
		wx = XWW'(width_q);
		hx = XWH'(height_q);
		if (wx < XWW'(2)) begin
			w_eff = WVB'(2);
		end else if (wx > XWW'(MAX_WIDTH)) begin
			w_eff = WVB'(MAX_WIDTH);
		end else begin
			w_eff = WVB'(wx);
		end
		if (hx < XWH'(2)) begin
			h_eff = HVB'(2);
		end else if (hx > XWH'(MAX_HEIGHT)) begin
			h_eff = HVB'(MAX_HEIGHT);
		end else begin
			h_eff = HVB'(hx);
		end
		w_last = CW'(w_eff - WVB'(1));
		h_last = RW'(h_eff - HVB'(1));
	end

	// Input stage (s1) and position counter
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          valid_s1;
	in_item_t      item_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          accept;
	logic          s1_to_s2;
	logic          s1_pixel;

	assign in_stall = valid_s1 && !s1_to_s2;
	assign accept   = in_valid && !in_stall;
	assign s1_pixel = item_s1.action == ACT_PIXEL;

	// Line buffer: entry c holds the last two rows seen at column c,
	// the newer one in the upper half.
	logic [2*D-1:0] lbuf [MAX_WIDTH];
	logic [2*D-1:0] lb_rd_q;

	always_ff @(posedge clk) begin
		if (accept && in_data.action == ACT_PIXEL) begin
			lb_rd_q <= lbuf[col_q];
		end
		if (s1_to_s2 && s1_pixel) begin
			lbuf[col_s1] <= {item_s1.sample, lb_rd_q[2*D-1:D]};
		end
	end

	// Window and job issue stage (s2)
	logic signed [D-1:0] win_s2 [KSIZE][KSIZE];
	logic signed [D-1:0] wt_q [NTAPS];
	logic signed [D-1:0] bias_q;
	logic [3:0]          pend_s2;
	logic [CW-1:0]       col_s2;
	logic [RW-1:0]       row_s2;
	logic                first_s2, last_s2;
	logic [3:0]          jobs_s1;
	logic [3:0]          jbit;
	logic                issue;
	logic                b_free;
	logic                hazard;
	logic                p0_free;
	job_t                job_nx;
	logic signed [2*D-1:0] prod_nx [NTAPS];

	assign jobs_s1[0] = row_s1 != '0 && col_s1 != '0;
	assign jobs_s1[1] = row_s1 != '0 && col_s1 == w_last;
	assign jobs_s1[2] = row_s1 == h_last && col_s1 != '0;
	assign jobs_s1[3] = row_s1 == h_last && col_s1 == w_last;

	always_comb begin
		jbit = 4'b0000;
		if (pend_s2[0]) begin
			jbit = 4'b0001;
		end else if (pend_s2[1]) begin
			jbit = 4'b0010;
		end else if (pend_s2[2]) begin
			jbit = 4'b0100;
		end else if (pend_s2[3]) begin
			jbit = 4'b1000;
		end
	end

	always_comb begin
		logic          rsh, csh;
		logic [1:0]    lowr, lowc, wr, wc;
		logic [RW-1:0] orow;
		logic [CW-1:0] ocol;
		logic signed [D-1:0] tpx;
		rsh  = jbit[2] || jbit[3];
		csh  = jbit[1] || jbit[3];
		orow = rsh ? row_s2 : row_s2 - RW'(1);
		ocol = csh ? col_s2 : col_s2 - CW'(1);
		lowr = (row_s2 == '0) ? 2'd2 : ((row_s2 == RW'(1)) ? 2'd1 : 2'd0);
		lowc = (col_s2 == '0) ? 2'd2 : ((col_s2 == CW'(1)) ? 2'd1 : 2'd0);
		for (int dr = 0; dr < KSIZE; dr++) begin
			for (int dc = 0; dc < KSIZE; dc++) begin
				wr = 2'(dr) + {1'b0, rsh};
				wc = 2'(dc) + {1'b0, csh};
				if (wr <= 2'd2 && wc <= 2'd2 && wr >= lowr && wc >= lowc) begin
					tpx = win_s2[wr][wc];
				end else begin
					tpx = '0;
				end
				prod_nx[KSIZE*dr+dc] = tpx * wt_q[KSIZE*dc+dr];
			end
		end
		job_nx.idx   = AW'(32'(orow) * MAX_WIDTH + 32'(ocol));
		job_nx.col   = 8'(ocol);
		job_nx.row   = 8'(orow);
		job_nx.done  = orow == h_last && ocol == w_last;
		job_nx.first = first_s2;
		job_nx.last  = last_s2;
		job_nx.bias  = bias_q;
	end

	// MAC pipe: stage k holds the sum after k taps; the last stage writes back.
	logic                        mac_v_s   [NSTG];
	logic                        mac_go    [NSTG];
	job_t                        job_s     [NSTG];
	logic signed [2*D-1:0]       prod_s    [NSTG][NTAPS];
	logic signed [ACC_BITS-1:0]  acc_s     [1:NSTG-1];
	logic signed [ACC_BITS-1:0]  acc_nx    [NSTG-1];
	logic signed [ACC_BITS-1:0]  acc_rd_q;
	logic signed [ACC_BITS-1:0]  accm [MAX_WIDTH*MAX_HEIGHT];
	logic                        out_free;

	always_comb begin
		hazard = 1'b0;
		for (int k = 0; k < NSTG; k++) begin
			if (mac_v_s[k] && job_s[k].idx == job_nx.idx) begin
				hazard = 1'b1;
			end
		end
	end

	assign p0_free = !mac_v_s[0] || mac_go[0];
	assign issue   = pend_s2 != 4'b0000 && p0_free && !hazard;
	assign b_free  = pend_s2 == 4'b0000 || ((pend_s2 & ~jbit) == 4'b0000 && issue);
	assign s1_to_s2 = valid_s1 && b_free;

	assign out_free = !out_valid || !out_stall;

	always_comb begin
		mac_go[NSTG-1] = mac_v_s[NSTG-1] && (!job_s[NSTG-1].last || out_free);
		for (int k = NSTG - 2; k >= 0; k--) begin
			mac_go[k] = mac_v_s[k] && (!mac_v_s[k+1] || mac_go[k+1]);
		end
	end

	always_comb begin
		acc_nx[0] = sat_add(job_s[0].first ? '0 : acc_rd_q, prod_clamp(prod_s[0][0]));
		for (int k = 1; k < NSTG - 1; k++) begin
			acc_nx[k] = sat_add(acc_s[k], prod_clamp(prod_s[k][k]));
		end
	end

	// Accumulator memory: read at issue, written as a job leaves the pipe.
	always_ff @(posedge clk) begin
		if (issue) begin
			acc_rd_q <= accm[job_nx.idx];
		end
		if (mac_go[NSTG-1]) begin
			accm[job_s[NSTG-1].idx] <= acc_s[NSTG-1];
		end
	end

	// Output value
	out_item_t out_nx;
	out_item_t out_q;
	logic      out_valid_q;

	always_comb begin
		logic signed [ACC_BITS-1:0] biased;
		logic signed [OW-1:0]       ve;
		biased = sat_add(acc_s[NSTG-1], ACC_BITS'(job_s[NSTG-1].bias));
		ve     = OW'(biased);
		out_nx.out_col    = job_s[NSTG-1].col;
		out_nx.out_row    = job_s[NSTG-1].row;
		out_nx.frame_done = job_s[NSTG-1].done;
		if (biased[ACC_BITS-1]) begin
			out_nx.out_value = '0;
		end else if (ve > OUT_MAX) begin
			out_nx.out_value = 32'(OUT_MAX);
		end else begin
			out_nx.out_value = 32'(ve);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= CFG_BITS'(256);
			height_q    <= CFG_BITS'(256);
			col_q       <= '0;
			row_q       <= '0;
			valid_s1    <= 1'b0;
			pend_s2     <= 4'b0000;
			bias_q      <= '0;
			out_valid_q <= 1'b0;
			for (int t = 0; t < NTAPS; t++) begin
				wt_q[t] <= '0;
			end
			for (int k = 0; k < NSTG; k++) begin
				mac_v_s[k] <= 1'b0;
			end
		end else begin
			if (cfg_valid && cfg_ready && cfg_index == CFG_IMAGE_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_valid && cfg_ready && cfg_index == CFG_IMAGE_HEIGHT) begin
				height_q <= cfg_data;
			end

			if (cfg_we) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept && in_data.action == ACT_PIXEL) begin
				if (col_q == w_last) begin
					col_q <= '0;
					row_q <= (row_q == h_last) ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end

			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_to_s2) begin
				valid_s1 <= 1'b0;
			end

			if (s1_to_s2) begin
				pend_s2 <= s1_pixel ? jobs_s1 : 4'b0000;
				if (item_s1.action == ACT_WEIGHT && item_s1.tap_index < 4'(NTAPS)) begin
					wt_q[item_s1.tap_index] <= item_s1.sample;
				end
				if (item_s1.action == ACT_BIAS) begin
					bias_q <= item_s1.sample;
				end
			end else if (issue) begin
				pend_s2 <= pend_s2 & ~jbit;
			end

			mac_v_s[0] <= issue ? 1'b1 : (mac_go[0] ? 1'b0 : mac_v_s[0]);
			for (int k = 1; k < NSTG; k++) begin
				mac_v_s[k] <= mac_go[k-1] ? 1'b1 : (mac_go[k] ? 1'b0 : mac_v_s[k]);
			end

			if (out_free) begin
				out_valid_q <= mac_go[NSTG-1] && job_s[NSTG-1].last;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
			col_s1  <= col_q;
			row_s1  <= row_q;
		end
		if (s1_to_s2 && s1_pixel) begin
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			first_s2 <= item_s1.first_plane;
			last_s2  <= item_s1.last_plane;
			for (int rr = 0; rr < KSIZE; rr++) begin
				win_s2[rr][0] <= win_s2[rr][1];
				win_s2[rr][1] <= win_s2[rr][2];
			end
			win_s2[0][2] <= lb_rd_q[D-1:0];
			win_s2[1][2] <= lb_rd_q[2*D-1:D];
			win_s2[2][2] <= item_s1.sample;
		end
		if (issue) begin
			job_s[0] <= job_nx;
			for (int t = 0; t < NTAPS; t++) begin
				prod_s[0][t] <= prod_nx[t];
			end
		end
		for (int k = 1; k < NSTG; k++) begin
			if (mac_go[k-1]) begin
				job_s[k] <= job_s[k-1];
				acc_s[k] <= acc_nx[k-1];
				for (int t = 0; t < NTAPS; t++) begin
					prod_s[k][t] <= prod_s[k-1][t];
				end
			end
		end
		if (out_free && mac_go[NSTG-1] && job_s[NSTG-1].last) begin
			out_q <= out_nx;
		end
	end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 same-padded convolution plane unit. Weight,
// bias and pixel requests are driven with random gaps and random output
// stalls. A scoreboard model predicts every finished output pixel, and each
// result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import cnv3_pkg::*;

	localparam int LIMIT    = 400000;
	localparam int DRAIN    = 40;
	localparam int N_RANDOM = 30;

	class conv_scoreboard;
		longint    wt[NTAPS];
		longint    bias;
		longint    lines[KSIZE][256];
		longint    accum[int];
		int        col, row, width, height;
		out_item_t expq[$];
		int        n_err, n_results;

		function new();
			foreach (wt[i]) wt[i] = 0;
			foreach (lines[i, j]) lines[i][j] = 0;
			bias = 0; col = 0; row = 0; width = 256; height = 256;
			n_err = 0; n_results = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, int val);
			if (idx == CFG_IMAGE_WIDTH)
				width = (val < 2) ? 2 : (val > 256) ? 256 : val;
			else if (idx == CFG_IMAGE_HEIGHT)
				height = (val < 2) ? 2 : (val > 256) ? 256 : val;
			col = 0;
			row = 0;
		endfunction

		function longint sat40(longint v);
			longint hi;
			hi = (longint'(1) <<< 39) - 1;
			if (v > hi) return hi;
			if (v < -hi - 1) return -hi - 1;
			return v;
		endfunction

		function longint pixel(int r, int c);
			if (r < 0 || c < 0 || r >= height || c >= width) return 0;
			return lines[r % KSIZE][c];
		endfunction

		function void finish(int r, int c, bit first, bit last);
			longint    acc;
			out_item_t o;
			acc = first ? 0 : accum[r * 256 + c];
			for (int dr = 0; dr < KSIZE; dr++)
				for (int dc = 0; dc < KSIZE; dc++)
					acc = sat40(acc + sat40(wt[KSIZE * dc + dr] * pixel(r - 1 + dr, c - 1 + dc)));
			accum[r * 256 + c] = acc;
			if (!last) return;
			acc = sat40(acc + bias);
			if (acc < 0) acc = 0;
			if (acc > 64'sd2147483647) acc = 64'sd2147483647;
			o.out_col    = c[7:0];
			o.out_row    = r[7:0];
			o.out_value  = acc[31:0];
			o.frame_done = (r == height - 1 && c == width - 1);
			expq.push_back(o);
		endfunction

		function void note_input(in_item_t x);
			int r, c;
			r = row;
			c = col;
			case (x.action)
				ACT_WEIGHT: if (x.tap_index < NTAPS) wt[x.tap_index] = longint'(x.sample);
				ACT_BIAS:   bias = longint'(x.sample);
				ACT_PIXEL: begin
					lines[r % KSIZE][c] = longint'(x.sample);
					if (r >= 1 && c >= 1) finish(r - 1, c - 1, x.first_plane, x.last_plane);
					if (r >= 1 && c == width - 1) finish(r - 1, c, x.first_plane, x.last_plane);
					if (r == height - 1 && c >= 1) finish(r, c - 1, x.first_plane, x.last_plane);
					if (r == height - 1 && c == width - 1)
						finish(r, c, x.first_plane, x.last_plane);
					if (c + 1 < width) begin
						col = c + 1;
					end else begin
						col = 0;
						row = (r + 1 < height) ? r + 1 : 0;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			n_results++;
			if (expq.size() == 0) begin
				$error("unexpected result col %0d row %0d", got.out_col, got.out_row);
				n_err++;
				return;
			end
			e = expq.pop_front();
			if (got.out_col !== e.out_col) begin
				$error("out_col expected %0d got %0d", e.out_col, got.out_col);
				n_err++;
			end
			if (got.out_row !== e.out_row) begin
				$error("out_row expected %0d got %0d", e.out_row, got.out_row);
				n_err++;
			end
			if (got.out_value !== e.out_value) begin
				$error("out_value expected %0d got %0d", e.out_value, got.out_value);
				n_err++;
			end
			if (got.frame_done !== e.frame_done) begin
				$error("frame_done expected %0d got %0d", e.frame_done, got.frame_done);
				n_err++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0] cfg_data = '0;

	conv_scoreboard sb = new();
	int  send_pct = 0, recv_pct = 0;
	int  n_sent = 0, n_planes = 0, n_cfg = 0, cycles = 0;
	logic hold_off = 1'b0;

	conv3x3_same_relu_plane_unit i_dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Output side: results are checked at the edge that accepts them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) sb.check_result(out_data);
			out_stall <= hold_off || ($urandom_range(99) < recv_pct);
		end
	end

	// Long hold-off of the receiver so that the block backs up into its input.
	initial begin
		wait (n_sent >= 150);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic push(in_item_t x);
		if ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= x;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(x);
		n_sent++;
	endtask

	// Registers are only written once the block has gone quiet.
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int val);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (sb.expq.size() == 0);
		repeat (DRAIN) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_BITS-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, val);
		n_cfg++;
	endtask

	function automatic in_item_t mk(logic [1:0] act, int tap, int smp, bit f, bit l);
		in_item_t x;
		x.action      = act;
		x.tap_index   = tap[3:0];
		x.sample      = smp[15:0];
		x.first_plane = f;
		x.last_plane  = l;
		return x;
	endfunction

	task automatic load_kernel(int wval, int bval);
		for (int t = 0; t < NTAPS; t++) push(mk(ACT_WEIGHT, t, wval, 0, 0));
		push(mk(ACT_BIAS, 0, bval, 0, 0));
	endtask

	// One plane of random or fixed_px pixels; a truncated plane is only ever the final one.
	task automatic send_plane(bit f, bit l, bit cut, int fixed_px, int max_px = 0);
		int npx, stop;
		npx  = sb.width * sb.height;
		stop = cut ? $urandom_range(npx - 1, 1) : npx;
		if (max_px != 0 && stop > max_px) stop = max_px;
		for (int i = 0; i < stop; i++) begin
			if ($urandom_range(99) < 4)
				push(mk(ACT_WEIGHT, $urandom_range(15), $urandom, 0, 0));
			if ($urandom_range(99) < 2) push(mk(ACT_SPARE, $urandom, $urandom, 1, 1));
			push(mk(ACT_PIXEL, $urandom, (fixed_px != 0) ? fixed_px : $urandom,
				f || ($urandom_range(99) < 2), l || ($urandom_range(99) < 2)));
		end
		n_planes++;
	endtask

	task automatic set_size(int w, int h);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
	endtask

	initial begin
		int np, wv, base;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: saturation high, ReLU clamp, unused action and bad tap.
		send_pct = 0;
		recv_pct = 0;
		set_size(2, 2);
		load_kernel(32767, 32767);
		send_plane(1, 1, 0, 32767);
		load_kernel(-32768, -32768);
		push(mk(ACT_WEIGHT, 15, 1234, 0, 0));
		push(mk(ACT_SPARE, 0, 32767, 1, 1));
		send_plane(1, 1, 0, 32767);
		// Register extremes, clamped to the largest and smallest sizes; only the
		// top of each large plane is sent.
		set_size(511, 0);
		load_kernel(1, 100);
		send_plane(1, 1, 0, 0, 260);
		set_size(1, 300);
		send_plane(1, 1, 0, 0, 12);

		// Random jobs: size, kernel, then a short stack of planes.
		base = n_sent;
		for (int ph = 0; ph < 3; ph++) begin
			send_pct = (ph == 0) ? 37 : (ph == 1) ? 58 : 0;
			recv_pct = (ph == 0) ? 58 : (ph == 1) ? 37 : 0;
			while (n_sent < base + (ph + 1) * N_RANDOM) begin
				if ($urandom_range(9) == 0) set_size($urandom_range(12, 2), $urandom_range(8, 2));
				else set_size($urandom_range(5, 2), $urandom_range(4, 2));
				for (int t = 0; t < NTAPS; t++) begin
					wv = ($urandom_range(9) == 0) ? -32768 : $urandom;
					push(mk(ACT_WEIGHT, t, wv, 0, 0));
				end
				push(mk(ACT_BIAS, 0, $urandom, 0, 0));
				np = $urandom_range(3, 1);
				for (int p = 0; p < np; p++)
					send_plane(p == 0, p == np - 1, (p == np - 1) && ($urandom_range(9) == 0), 0);
			end
		end

		in_valid <= 1'b0;
		wait (sb.expq.size() == 0);
		repeat (DRAIN) @(posedge clk);
		$display("Sent %0d requests in %0d planes with %0d register writes.",
			n_sent, n_planes, n_cfg);
		$display("Checked %0d output pixels, %0d mismatches.", sb.n_results, sb.n_err);
		if (sb.n_err == 0 && sb.expq.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

/* sim.f */
src/cnv3_pkg.sv
src/conv3x3_same_relu_plane_unit.sv
test/tb_top.sv
